FILE: rtl/dplb_pkg.sv
// Shared types, constants and mode codes for the dual phase LFO.
package dplb_pkg;

    // Phase format: Q1.PHASE_FRAC_BITS, 1.0 = 2^PHASE_FRAC_BITS
    localparam int PHASE_FRAC_BITS = 24;
    localparam int PHASE_W         = PHASE_FRAC_BITS + 1;
    localparam int CALC_W          = PHASE_FRAC_BITS + 3;
    localparam logic [PHASE_W-1:0] PH_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;

    // Field widths
    localparam int INC_W    = 25;
    localparam int MPOS_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int BLEND_W  = 17;
    localparam int SCALE_W  = 16;
    localparam int OUT_PH_W = 25;

    // Blend weight full scale (1.0 in Q1.16)
    localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(65536);

    // Direction mode codes
    localparam logic [1:0] MODE_FWD    = 2'd0;
    localparam logic [1:0] MODE_BACK   = 2'd1;
    localparam logic [1:0] MODE_BIDIR  = 2'd2;
    localparam logic [1:0] MODE_BOUNCE = 2'd3;

    typedef struct packed {
        logic [INC_W-1:0]          free_increment;
        logic [INC_W-1:0]          sync_increment;
        logic                      freeze;
        logic                      reset_button;
        logic                      sync_restart;
        logic                      bar_length_rate;
        logic [MPOS_W-1:0]         measure_position;
        logic [BLEND_W-1:0]        blend_amount;
        logic signed [SCALE_W-1:0] output_scale;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0]    mod_value;
        logic [OUT_PH_W-1:0]   free_phase_out;
        logic [OUT_PH_W-1:0]   sync_phase_out;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic step_first;
        logic step_again;
        logic weigh;
        logic sum;
        logic scale;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic bounce;
    } t_dp_sts;

endpackage

FILE: rtl/dplb_ctrl.sv
// Sequencing state machine and output valid flag for the dual phase LFO.
module dplb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  dplb_pkg::t_dp_sts i_sts,
    output dplb_pkg::t_dp_cmd o_cmd
);
    import dplb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STEP   = 3'd1;
    localparam logic [2:0] S_BOUNCE = 3'd2;
    localparam logic [2:0] S_WEIGH  = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_SCALE  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // Output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    // Commands depend on the state and the handshakes only
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
            end
            S_STEP: begin
                o_cmd.step_first = 1'b1;
            end
            S_BOUNCE: begin
                o_cmd.step_again = 1'b1;
            end
            S_WEIGH: begin
                o_cmd.weigh = 1'b1;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_state = i_sts.bounce ? S_BOUNCE : S_WEIGH;
            end
            S_BOUNCE: begin
                n_state = S_WEIGH;
            end
            S_WEIGH: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Set valid on load, drop it when the transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/dplb_datapath.sv
// Phase state, shared step unit, blend and scale arithmetic for the dual phase LFO.
module dplb_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    input  dplb_pkg::t_in_item  i_in_data,
    input  dplb_pkg::t_dp_cmd   i_cmd,
    output dplb_pkg::t_dp_sts   o_sts,
    output dplb_pkg::t_out_item o_out_data
);
    import dplb_pkg::*;

    localparam int PROD_W = PHASE_W + BLEND_W;
    localparam int MAG_W  = PROD_W + SCALE_W;
    localparam int RND_SH = PHASE_FRAC_BITS + 16;
    localparam int Q_W    = MAG_W + 1 - RND_SH;
    localparam logic signed [CALC_W-1:0] ONE_C = signed'(CALC_W'(PH_ONE));
    localparam logic signed [CALC_W-1:0] TWO_C = ONE_C <<< 1;
    localparam logic [MAG_W:0] RND_HALF = (MAG_W+1)'(1) << (RND_SH - 1);

    // Configuration and oscillator state
    logic [1:0]               r_mode;
    logic signed [CALC_W-1:0] r_free_ph;
    logic signed [CALC_W-1:0] r_sync_ph;
    logic                     r_free_back;
    logic                     r_sync_back;
    logic                     r_free_done;
    logic                     r_sync_armed;
    logic [MPOS_W-1:0]        r_last_mpos;
    logic [FRAC_W-1:0]        r_last_frac;

    // Item and arithmetic pipeline registers
    t_in_item                 r_in;
    logic [PROD_W-1:0]        r_prod_free;
    logic [PROD_W-1:0]        r_prod_sync;
    logic [PROD_W-1:0]        r_sum;
    logic [MAG_W-1:0]         r_mag;
    t_out_item                r_out;

    // Step unit signals
    logic                     reflect;
    logic [INC_W-1:0]         sat_free_inc;
    logic [INC_W-1:0]         sat_sync_inc;
    logic signed [CALC_W-1:0] inc_f;
    logic signed [CALC_W-1:0] inc_s;
    logic                     dir_f;
    logic                     dir_s;
    logic signed [CALC_W-1:0] tf;
    logic signed [CALC_W-1:0] ts;
    logic                     nf_back;
    logic                     ns_back;
    logic                     nf_done;
    logic                     ns_armed;
    logic                     fire;
    logic [FRAC_W-1:0]        cur_frac;

    // Blend and output signals
    logic [PHASE_W-1:0]       clamp_free;
    logic [PHASE_W-1:0]       clamp_sync;
    logic [BLEND_W-1:0]       w_sync;
    logic [BLEND_W-1:0]       w_free;
    logic                     scale_neg;
    logic [SCALE_W-1:0]       scale_abs;
    logic [MAG_W:0]           rnd;
    logic [Q_W-1:0]           q;
    logic signed [15:0]       mod;

    assign reflect  = (r_mode == MODE_BIDIR) || (r_mode == MODE_BOUNCE);
    assign cur_frac = r_in.measure_position[FRAC_W-1:0];

    // Saturate increments at 1.0
    assign sat_free_inc = (r_in.free_increment > INC_W'(PH_ONE)) ? INC_W'(PH_ONE)
                                                                 : r_in.free_increment;
    assign sat_sync_inc = (r_in.sync_increment > INC_W'(PH_ONE)) ? INC_W'(PH_ONE)
                                                                 : r_in.sync_increment;
    assign inc_f = signed'(CALC_W'(sat_free_inc));
    assign inc_s = signed'(CALC_W'(sat_sync_inc));

    // Directions: by mode or kept on the first pass, flipped on the bounce repeat
    always_comb begin
        if (i_cmd.step_first) begin
            if (r_mode == MODE_FWD) begin
                dir_f = 1'b0;
                dir_s = 1'b0;
            end else if (r_mode == MODE_BACK) begin
                dir_f = 1'b1;
                dir_s = 1'b1;
            end else begin
                dir_f = r_free_back;
                dir_s = r_sync_back;
            end
        end else begin
            dir_f = !r_free_back;
            dir_s = !r_sync_back;
        end
    end

    // Free phase step: reset press, wrap or reflect
    always_comb begin
        tf      = r_free_ph;
        nf_back = dir_f;
        nf_done = r_free_done;
        if (!r_in.freeze) begin
            if (r_in.reset_button && !r_free_done) begin
                tf      = '0;
                nf_done = 1'b1;
            end else begin
                nf_done = r_in.reset_button;
                if (!dir_f) begin
                    tf = r_free_ph + inc_f;
                    if (tf > ONE_C) begin
                        if (r_mode == MODE_FWD) begin
                            tf = tf - ONE_C;
                        end else if (reflect) begin
                            nf_back = 1'b1;
                            tf      = TWO_C - tf;
                        end
                    end
                end else begin
                    tf = r_free_ph - inc_f;
                    if (tf[CALC_W-1]) begin
                        if (r_mode == MODE_BACK) begin
                            tf = tf + ONE_C;
                        end else if (reflect) begin
                            nf_back = 1'b0;
                            tf      = -tf;
                        end
                    end
                end
            end
        end
    end

    // Sync phase step: wrap or turn at the ends, arm and fire the beat or bar reset
    always_comb begin
        ts       = r_sync_ph;
        ns_back  = dir_s;
        ns_armed = r_sync_armed;
        fire     = 1'b0;
        if (!r_in.freeze) begin
            ns_armed = r_sync_armed | r_in.reset_button;
            if (!dir_s) begin
                ts = r_sync_ph + inc_s;
                if (ts > ONE_C && r_mode == MODE_FWD) begin
                    ts = ts - ONE_C;
                end else if (ts >= ONE_C && reflect) begin
                    ns_back = 1'b1;
                    if (ts > ONE_C) begin
                        ts = TWO_C - ts;
                    end
                end
            end else begin
                ts = r_sync_ph - inc_s;
                if (ts[CALC_W-1] && r_mode == MODE_BACK) begin
                    ts = ts + ONE_C;
                end else if ((ts[CALC_W-1] || ts == '0) && reflect) begin
                    ns_back = 1'b0;
                    if (ts[CALC_W-1]) begin
                        ts = -ts;
                    end
                end
            end
            if (i_cmd.step_first) begin
                ns_armed = ns_armed | r_in.sync_restart;
                fire = r_in.bar_length_rate ? (r_in.measure_position < r_last_mpos)
                                            : (cur_frac < r_last_frac);
                if (ns_armed && fire) begin
                    ts       = '0;
                    ns_armed = 1'b0;
                end
            end
        end
    end

    // In bounce mode, bounce when the step changes which phase leads
    assign o_sts.bounce = (r_mode == MODE_BOUNCE) &&
                          ((r_sync_ph > r_free_ph) != (ts > tf));

    // Clamp phases to 0..1.0
    always_comb begin
        if (r_free_ph[CALC_W-1]) begin
            clamp_free = '0;
        end else if (r_free_ph > ONE_C) begin
            clamp_free = PH_ONE;
        end else begin
            clamp_free = r_free_ph[PHASE_W-1:0];
        end
        if (r_sync_ph[CALC_W-1]) begin
            clamp_sync = '0;
        end else if (r_sync_ph > ONE_C) begin
            clamp_sync = PH_ONE;
        end else begin
            clamp_sync = r_sync_ph[PHASE_W-1:0];
        end
    end

    // Blend weights
    assign w_sync = (r_in.blend_amount > BLEND_ONE) ? BLEND_ONE : r_in.blend_amount;
    assign w_free = BLEND_ONE - w_sync;

    // Scale magnitude and sign
    assign scale_neg = r_in.output_scale[SCALE_W-1];
    assign scale_abs = scale_neg ? SCALE_W'(-r_in.output_scale)
                                 : SCALE_W'(r_in.output_scale);

    // Round half away from zero on the magnitude, then saturate
    assign rnd = {1'b0, r_mag} + RND_HALF;
    assign q   = rnd[MAG_W:RND_SH];
    always_comb begin
        if (!scale_neg) begin
            mod = (q >= Q_W'(32768)) ? 16'sd32767 : signed'(q[15:0]);
        end else begin
            mod = (q >= Q_W'(32768)) ? -16'sd32768 : -signed'(q[15:0]);
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BIDIR;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // Oscillator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_ph    <= '0;
            r_sync_ph    <= '0;
            r_free_back  <= 1'b0;
            r_sync_back  <= 1'b0;
            r_free_done  <= 1'b0;
            r_sync_armed <= 1'b0;
            r_last_mpos  <= '0;
            r_last_frac  <= '0;
        end else begin
            if (i_cmd.step_first || i_cmd.step_again) begin
                r_free_ph    <= tf;
                r_sync_ph    <= ts;
                r_free_back  <= nf_back;
                r_sync_back  <= ns_back;
                r_free_done  <= nf_done;
                r_sync_armed <= ns_armed;
            end else if (i_cmd.weigh) begin
                r_free_ph <= signed'(CALC_W'(clamp_free));
                r_sync_ph <= signed'(CALC_W'(clamp_sync));
            end
            if (i_cmd.step_first && !r_in.freeze) begin
                r_last_mpos <= r_in.measure_position;
                r_last_frac <= cur_frac;
            end
        end
    end

    // Item capture and arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.weigh) begin
            r_prod_free <= PROD_W'(clamp_free * w_free);
            r_prod_sync <= PROD_W'(clamp_sync * w_sync);
        end
        if (i_cmd.sum) begin
            r_sum <= r_prod_free + r_prod_sync;
        end
        if (i_cmd.scale) begin
            r_mag <= MAG_W'(r_sum * scale_abs);
        end
        if (i_cmd.load_out) begin
            r_out.mod_value      <= mod;
            r_out.free_phase_out <= OUT_PH_W'(r_free_ph[PHASE_W-1:0]);
            r_out.sync_phase_out <= OUT_PH_W'(r_sync_ph[PHASE_W-1:0]);
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: rtl/dual_phase_lfo_bounce.sv
// Top level of the dual phase LFO with bounce: controller, datapath and checks.
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_stall     i_in_data  (t_in_item)
//   out      output     o_out_valid / i_out_stall   o_out_data (t_out_item)
//   cfg      input      i_cfg_wr_en                 i_cfg_wr_data (direction mode)
//
// A result passes from its input transaction through the step state, a repeated
// step when bounce mode calls for one, and the weigh, sum, scale and done states;
// one shared step unit runs both passes, and the blend products, their sum and the
// gain multiply take one registered stage each. A new input is taken only in idle.
// Reset is synchronous; it zeroes both phases and sets the bidirectional mode.
// A stall on the output holds the result register; the block finishes the
// next item and waits in its last stage until that register is free.
module dual_phase_lfo_bounce (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dplb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dplb_pkg::t_out_item o_out_data
);
    import dplb_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    dplb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    dplb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_out_data    (o_out_data)
    );

    // Phases leave the block clamped to 0..1.0
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.free_phase_out <= OUT_PH_W'(PH_ONE)))
        else $error("free phase out of range");

    a_sync_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.sync_phase_out <= OUT_PH_W'(PH_ONE)))
        else $error("sync phase out of range");

    // An accepted transaction keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again without processing");

    // Result is loaded only in the final stage, never with a step or an input load
    a_load_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> !(dp_cmd.step_first || dp_cmd.step_again || dp_cmd.load_in))
        else $error("result load overlaps a step");

endmodule
